// ===== hdl/cct_pkg.sv =====
`timescale 1ns / 1ps

package cct_pkg;

  // Width of the internal byte offsets; outputs carry the low 32 bits.
  localparam int unsigned POS_WIDTH = 32;
  localparam int unsigned OUT_WIDTH = 32;
  localparam int unsigned CFG_IDX_WIDTH = 3;

  typedef logic [POS_WIDTH-1:0] pos_t;

  localparam pos_t POS_MAX = '1;

  localparam logic [7:0] NUL_BYTE = 8'h00;
  localparam logic [7:0] SPACE_BYTE = 8'h20;
  localparam logic [7:0] TAB_BYTE = 8'h09;
  localparam logic [7:0] CR_BYTE = 8'h0d;

  localparam logic [7:0] COLUMN_CHAR_RST = 8'd44;
  localparam logic [7:0] ROW_CHAR_RST = 8'd13;
  localparam logic [7:0] ROW_FOLLOW_CHAR_RST = 8'd10;
  localparam logic [7:0] QUOTE_CHAR_RST = 8'd34;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    CFG_COLUMN_CHAR     = 3'd0,
    CFG_ROW_CHAR        = 3'd1,
    CFG_ROW_FOLLOW_CHAR = 3'd2,
    CFG_QUOTE_CHAR      = 3'd3,
    CFG_KEEP_QUOTES     = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] column_char;
    logic [7:0] row_char;
    logic [7:0] row_follow_char;
    logic [7:0] quote_char;
    logic       keep_quotes;
  } cfg_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [OUT_WIDTH-1:0] cell_start;
    logic [OUT_WIDTH-1:0] cell_length;
    logic                 row_end;
    logic                 quoted;
  } cell_desc_t;

  function automatic pos_t sat_inc(pos_t v);
    return (v == POS_MAX) ? POS_MAX : pos_t'(v + pos_t'(1));
  endfunction

  function automatic logic is_space(logic [7:0] b);
    return (b == SPACE_BYTE) || (b inside {[TAB_BYTE:CR_BYTE]});
  endfunction

  function automatic logic [OUT_WIDTH-1:0] to_out(pos_t v);
    logic [63:0] w;
    w = 64'(v);
    return w[OUT_WIDTH-1:0];
  endfunction

endpackage

// ===== hdl/cct_core.sv =====
`timescale 1ns / 1ps

module cct_core import cct_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       acc_i,
  input  in_item_t   item_i,
  input  cfg_t       cfg_i,
  output logic       res_valid_o,
  output cell_desc_t res_o
);

  pos_t position_q, position_d;
  pos_t cell_begin_q, cell_begin_d;
  pos_t quote_open_q, quote_open_d;
  pos_t quote_start_q, quote_start_d;
  pos_t quote_len_q, quote_len_d;
  pos_t first_ns_q, first_ns_d;
  pos_t last_ns_end_q, last_ns_end_d;
  logic seen_ns_q, seen_ns_d;
  logic inside_q, inside_d;
  logic have_quote_q, have_quote_d;
  logic skip_follow_q, skip_follow_d;
  logic [7:0] prev_q, prev_d;

  logic [7:0] b;
  logic       term;
  pos_t       cur, nxt_pos;
  logic       skip, ends, row, do_close, do_open, after_row;
  logic       hq_eff;
  pos_t       qs_eff, ql_eff;

  assign term = item_i.end_of_text;
  assign b    = term ? NUL_BYTE : item_i.text_byte;
  assign cur  = position_q;
  assign nxt_pos = sat_inc(cur);
  assign after_row = (cur != '0) &&
                     (prev_q == cfg_i.row_char || prev_q == cfg_i.row_follow_char);

  // Byte classification; column, NUL, row, quote in priority order.
  always_comb begin
    skip     = skip_follow_q && (b == cfg_i.row_follow_char);
    ends     = 1'b0;
    row      = 1'b0;
    do_close = 1'b0;
    do_open  = 1'b0;
    if (!skip) begin
      if (!term && b == cfg_i.column_char) begin
        ends = !inside_q;
      end else if (b == NUL_BYTE) begin
        if (!after_row) begin
          ends     = 1'b1;
          row      = 1'b1;
          do_close = inside_q;
        end
      end else if (b == cfg_i.row_char) begin
        ends     = 1'b1;
        row      = 1'b1;
        do_close = inside_q;
      end else if (b == cfg_i.quote_char && !cfg_i.keep_quotes) begin
        do_close = inside_q;
        do_open  = !inside_q;
      end
    end
  end

  assign hq_eff = do_close | have_quote_q;
  assign qs_eff = do_close ? sat_inc(quote_open_q) : quote_start_q;
  assign ql_eff = do_close ? ((cur > quote_open_q) ? pos_t'(cur - quote_open_q - pos_t'(1))
                                                    : '0)
                           : quote_len_q;

  always_comb begin
    res_valid_o = ends && !skip;
    res_o       = '0;
    if (hq_eff) begin
      res_o.cell_start  = to_out(qs_eff);
      res_o.cell_length = to_out(ql_eff);
    end else if (seen_ns_q) begin
      res_o.cell_start  = to_out(first_ns_q);
      res_o.cell_length = to_out(pos_t'(last_ns_end_q - first_ns_q));
    end else begin
      res_o.cell_start  = to_out(cell_begin_q);
      res_o.cell_length = '0;
    end
    res_o.row_end = row;
    res_o.quoted  = hq_eff;
  end

  always_comb begin
    position_d    = position_q;
    cell_begin_d  = cell_begin_q;
    quote_open_d  = quote_open_q;
    quote_start_d = quote_start_q;
    quote_len_d   = quote_len_q;
    first_ns_d    = first_ns_q;
    last_ns_end_d = last_ns_end_q;
    seen_ns_d     = seen_ns_q;
    inside_d      = inside_q;
    have_quote_d  = have_quote_q;
    skip_follow_d = skip_follow_q;
    prev_d        = prev_q;
    if (acc_i) begin
      skip_follow_d = 1'b0;
      position_d    = nxt_pos;
      prev_d        = b;
      if (skip) begin
        cell_begin_d = nxt_pos;
      end else begin
        have_quote_d  = hq_eff;
        quote_start_d = qs_eff;
        quote_len_d   = ql_eff;
        if (do_close) begin
          inside_d = 1'b0;
        end else if (do_open) begin
          inside_d     = 1'b1;
          quote_open_d = cur;
        end
        if (!ends) begin
          if (!is_space(b)) begin
            if (!seen_ns_q) begin
              first_ns_d = cur;
              seen_ns_d  = 1'b1;
            end
            last_ns_end_d = nxt_pos;
          end
        end else begin
          cell_begin_d  = nxt_pos;
          have_quote_d  = 1'b0;
          seen_ns_d     = 1'b0;
          skip_follow_d = row;
        end
      end
      // terminator: back to the reset state, whether or not it closed a row
      if (term) begin
        position_d    = '0;
        cell_begin_d  = '0;
        quote_open_d  = '0;
        quote_start_d = '0;
        quote_len_d   = '0;
        first_ns_d    = '0;
        last_ns_end_d = '0;
        seen_ns_d     = 1'b0;
        inside_d      = 1'b0;
        have_quote_d  = 1'b0;
        skip_follow_d = 1'b0;
        prev_d        = NUL_BYTE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      position_q    <= '0;
      cell_begin_q  <= '0;
      quote_open_q  <= '0;
      quote_start_q <= '0;
      quote_len_q   <= '0;
      first_ns_q    <= '0;
      last_ns_end_q <= '0;
      seen_ns_q     <= 1'b0;
      inside_q      <= 1'b0;
      have_quote_q  <= 1'b0;
      skip_follow_q <= 1'b0;
      prev_q        <= NUL_BYTE;
    end else begin
      position_q    <= position_d;
      cell_begin_q  <= cell_begin_d;
      quote_open_q  <= quote_open_d;
      quote_start_q <= quote_start_d;
      quote_len_q   <= quote_len_d;
      first_ns_q    <= first_ns_d;
      last_ns_end_q <= last_ns_end_d;
      seen_ns_q     <= seen_ns_d;
      inside_q      <= inside_d;
      have_quote_q  <= have_quote_d;
      skip_follow_q <= skip_follow_d;
      prev_q        <= prev_d;
    end
  end

`ifndef SYNTH
  a_term_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_i && term |=> position_q == '0 && !skip_follow_q && !inside_q)
    else $error("state not cleared after terminator");

  a_row_arms_skip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_i && !term && res_valid_o && res_o.row_end |=> skip_follow_q && !inside_q)
    else $error("row end did not arm follow skip");

  a_pos_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_i && !term && position_q != POS_MAX |=>
      position_q == pos_t'($past(position_q) + pos_t'(1)))
    else $error("position did not advance by one");
`endif

endmodule

// ===== hdl/csv_cell_tokenizer_unit.sv =====
`timescale 1ns / 1ps

// CSV cell tokenizer: takes one text byte per cycle and returns one descriptor
// (start offset, length, row-end and quoted marks) per finished cell, in the
// cycle after the byte that closes the cell. Every byte is classified and the
// cell state updated as it is accepted, so the sustained rate is one byte per
// clock; the only stall is a result held in the output register while the
// receiver is not ready, which holds off the next byte whether or not it
// closes a cell. The configuration port is always ready and should be written
// only while no transaction is in flight.

module csv_cell_tokenizer_unit import cct_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  in_item_t                 in_item_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output cell_desc_t               out_cell_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_IDX_WIDTH-1:0] cfg_index_i,
  input  logic [7:0]               cfg_data_i
);

  cfg_t       cfg_q, cfg_d;
  logic       out_valid_q, out_valid_d;
  cell_desc_t out_cell_q;
  logic       in_acc;
  logic       res_valid;
  cell_desc_t res;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_cell_o  = out_cell_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_COLUMN_CHAR:     cfg_d.column_char     = cfg_data_i;
        CFG_ROW_CHAR:        cfg_d.row_char        = cfg_data_i;
        CFG_ROW_FOLLOW_CHAR: cfg_d.row_follow_char = cfg_data_i;
        CFG_QUOTE_CHAR:      cfg_d.quote_char      = cfg_data_i;
        CFG_KEEP_QUOTES:     cfg_d.keep_quotes     = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  cct_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (in_acc),
    .item_i      (in_item_i),
    .cfg_i       (cfg_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_acc) begin
      out_valid_d = res_valid;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.column_char     <= COLUMN_CHAR_RST;
      cfg_q.row_char        <= ROW_CHAR_RST;
      cfg_q.row_follow_char <= ROW_FOLLOW_CHAR_RST;
      cfg_q.quote_char      <= QUOTE_CHAR_RST;
      cfg_q.keep_quotes     <= 1'b0;
      out_valid_q           <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && res_valid) begin
      out_cell_q <= res;
    end
  end

`ifndef SYNTH
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |-> !in_ready_o)
    else $error("input taken while result stalled");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(in_acc && res_valid))
    else $error("result without a closing byte");

  a_drop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !res_valid |=> !out_valid_q)
    else $error("stale result after a non-closing byte");
`endif

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import cct_pkg::*;

  logic clk = 1'b0;
  logic rst_n;

  logic                     in_valid;
  logic                     in_ready;
  in_item_t                 in_item;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  cell_desc_t               out_cell;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CFG_IDX_WIDTH-1:0] cfg_index;
  logic [7:0]               cfg_data;

  csv_cell_tokenizer_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_cell_o  (out_cell),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #1000000;
    $display("*** FAILED ***");
    $finish;
  end

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned mismatch_count;

  cell_desc_t expected_cells[$];

  // Tokenizer shadow state and register copy
  cfg_t       tok_cfg;
  pos_t       tok_pos;
  pos_t       tok_cell_begin;
  pos_t       tok_quote_open;
  pos_t       tok_quote_start;
  pos_t       tok_quote_len;
  pos_t       tok_first_text;
  pos_t       tok_text_end;
  logic       tok_seen_text;
  logic       tok_in_quote;
  logic       tok_have_quote;
  logic       tok_skip_follow;
  logic [7:0] tok_prev;

  function automatic pos_t pos_step(pos_t v);
    if (v == '1) return v;
    return v + pos_t'(1);
  endfunction

  function automatic logic is_blank(logic [7:0] b);
    return (b == 8'd32) || (b >= 8'd9 && b <= 8'd13);
  endfunction

  task automatic clear_tokenizer();
    tok_pos         = '0;
    tok_cell_begin  = '0;
    tok_quote_open  = '0;
    tok_quote_start = '0;
    tok_quote_len   = '0;
    tok_first_text  = '0;
    tok_text_end    = '0;
    tok_seen_text   = 1'b0;
    tok_in_quote    = 1'b0;
    tok_have_quote  = 1'b0;
    tok_skip_follow = 1'b0;
    tok_prev        = '0;
  endtask

  task automatic close_quote_at(pos_t at);
    tok_have_quote  = 1'b1;
    tok_quote_start = pos_step(tok_quote_open);
    tok_quote_len   = (at > tok_quote_open) ? at - tok_quote_open - pos_t'(1) : '0;
    tok_in_quote    = 1'b0;
  endtask

  // Advances the shadow tokenizer by one accepted transaction.
  task automatic predict_cell(in_item_t item);
    logic [7:0] b;
    logic       term;
    logic       consumed;
    logic       ends;
    logic       row_done;
    pos_t       cur;
    cell_desc_t d;
    term     = item.end_of_text;
    b        = term ? NUL_BYTE : item.text_byte;
    cur      = tok_pos;
    consumed = 1'b0;
    ends     = 1'b0;
    row_done = 1'b0;
    if (tok_skip_follow) begin
      tok_skip_follow = 1'b0;
      if (b == tok_cfg.row_follow_char) begin
        tok_prev       = b;
        tok_pos        = pos_step(cur);
        tok_cell_begin = tok_pos;
        consumed       = 1'b1;
      end
    end
    if (!consumed) begin
      if (!term && b == tok_cfg.column_char) begin
        ends = !tok_in_quote;
      end else if (b == NUL_BYTE) begin
        // NUL right after a row end is plain content, except at offset 0
        if (!(cur != '0 && (tok_prev == tok_cfg.row_char ||
                            tok_prev == tok_cfg.row_follow_char))) begin
          ends     = 1'b1;
          row_done = 1'b1;
          if (tok_in_quote) close_quote_at(cur);
        end
      end else if (b == tok_cfg.row_char) begin
        ends     = 1'b1;
        row_done = 1'b1;
        if (tok_in_quote) close_quote_at(cur);
      end else if (b == tok_cfg.quote_char && !tok_cfg.keep_quotes) begin
        if (tok_in_quote) begin
          close_quote_at(cur);
        end else begin
          tok_quote_open = cur;
          tok_in_quote   = 1'b1;
        end
      end
      tok_prev = b;
      tok_pos  = pos_step(cur);
      if (!ends) begin
        if (!is_blank(b)) begin
          if (!tok_seen_text) begin
            tok_first_text = cur;
            tok_seen_text  = 1'b1;
          end
          tok_text_end = pos_step(cur);
        end
      end else begin
        if (tok_have_quote) begin
          d.cell_start  = tok_quote_start[OUT_WIDTH-1:0];
          d.cell_length = tok_quote_len[OUT_WIDTH-1:0];
        end else if (tok_seen_text) begin
          d.cell_start  = tok_first_text[OUT_WIDTH-1:0];
          d.cell_length = OUT_WIDTH'(tok_text_end - tok_first_text);
        end else begin
          d.cell_start  = tok_cell_begin[OUT_WIDTH-1:0];
          d.cell_length = '0;
        end
        d.row_end      = row_done;
        d.quoted       = tok_have_quote;
        expected_cells.push_back(d);
        tok_have_quote = 1'b0;
        tok_seen_text  = 1'b0;
        tok_cell_begin = tok_pos;
        if (row_done) tok_skip_follow = 1'b1;
      end
    end
    if (term) clear_tokenizer();
  endtask

  // Receiver side: random back-pressure, changed on the falling edge
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    cell_desc_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_cells.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected cell: start=%0d len=%0d row_end=%0b quoted=%0b",
                   out_cell.cell_start, out_cell.cell_length, out_cell.row_end,
                   out_cell.quoted);
      end else begin
        want = expected_cells.pop_front();
        if (want.cell_start !== out_cell.cell_start ||
            want.cell_length !== out_cell.cell_length ||
            want.row_end !== out_cell.row_end ||
            want.quoted !== out_cell.quoted) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("cell mismatch: expected start=%0d len=%0d row_end=%0b quoted=%0b, got start=%0d len=%0d row_end=%0b quoted=%0b",
                     want.cell_start, want.cell_length, want.row_end, want.quoted,
                     out_cell.cell_start, out_cell.cell_length, out_cell.row_end,
                     out_cell.quoted);
        end
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(in_item_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_item  = item;
    do @(posedge clk); while (!in_ready);
    predict_cell(item);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic send_byte(logic [7:0] b);
    in_item_t item;
    item.text_byte   = b;
    item.end_of_text = 1'b0;
    send_item(item);
  endtask

  task automatic send_end_of_text();
    in_item_t item;
    item.text_byte   = 8'($urandom_range(255));
    item.end_of_text = 1'b1;
    send_item(item);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // Drain outstanding cells, then allow for a byte still in flight.
  task automatic wait_drained();
    while (expected_cells.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [7:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_COLUMN_CHAR:     tok_cfg.column_char     = data;
      CFG_ROW_CHAR:        tok_cfg.row_char        = data;
      CFG_ROW_FOLLOW_CHAR: tok_cfg.row_follow_char = data;
      CFG_QUOTE_CHAR:      tok_cfg.quote_char      = data;
      CFG_KEEP_QUOTES:     tok_cfg.keep_quotes     = data[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic load_registers(logic [7:0] column, logic [7:0] row, logic [7:0] follow,
                                logic [7:0] quote, logic keep);
    wait_drained();
    write_reg(CFG_COLUMN_CHAR, column);
    write_reg(CFG_ROW_CHAR, row);
    write_reg(CFG_ROW_FOLLOW_CHAR, follow);
    write_reg(CFG_QUOTE_CHAR, quote);
    write_reg(CFG_KEEP_QUOTES, {7'($urandom_range(127)), keep});
  endtask

  function automatic logic [7:0] pick_text_byte();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 38) return 8'($urandom_range(122, 97));
    if (r < 46) return ($urandom_range(1) != 0) ? SPACE_BYTE : TAB_BYTE;
    if (r < 60) return tok_cfg.column_char;
    if (r < 70) return tok_cfg.quote_char;
    if (r < 78) return tok_cfg.row_char;
    if (r < 82) return tok_cfg.row_follow_char;
    if (r < 87) return NUL_BYTE;
    return 8'($urandom_range(255));
  endfunction

  // Mostly delimited rows with random content, with noise mixed in.
  task automatic send_random_text(int unsigned count);
    int unsigned sent;
    logic [7:0]  b;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(99) < 2) begin
        send_end_of_text();
        sent++;
      end else begin
        b = pick_text_byte();
        send_byte(b);
        sent++;
        if (b == tok_cfg.row_char && $urandom_range(99) < 70) begin
          send_byte(tok_cfg.row_follow_char);
          sent++;
        end
      end
    end
  endtask

  // Default registers: trimming, quoted cells, empty cells, row ends, NUL rules
  task automatic test_basic_cells();
    send_byte(8'hff);
    send_text(" a ,\"x\",,\015\012");
    send_byte(NUL_BYTE);           // follows a row-follow byte: content
    send_text("\"a\015");          // open quote closed by the row end
    send_byte(NUL_BYTE);           // follows a row byte: content
    send_text("b");
    send_byte(NUL_BYTE);           // ends the row
    send_end_of_text();
    send_byte(NUL_BYTE);           // offset 0, no previous byte
    send_text("\"a\"\"b\",");      // last closed pair wins
  endtask

  task automatic test_default_stream();
    load_registers(COLUMN_CHAR_RST, ROW_CHAR_RST, ROW_FOLLOW_CHAR_RST, QUOTE_CHAR_RST,
                   1'b0);
    send_random_text(65);
  endtask

  task automatic test_alternate_delimiters();
    load_registers(8'd59, 8'd10, 8'd13, 8'd39, 1'b1);
    send_random_text(65);
  endtask

  // Column char on NUL, row and quote sharing a code, follow on NUL
  task automatic test_low_register_values();
    load_registers(8'h00, 8'hff, 8'h00, 8'hff, 1'b0);
    send_random_text(65);
  endtask

  task automatic test_high_register_values();
    load_registers(8'hff, 8'h00, 8'hff, 8'h00, 1'b1);
    send_random_text(65);
  endtask

  task automatic test_random_registers();
    load_registers(8'($urandom_range(255)), 8'($urandom_range(255)),
                   8'($urandom_range(255)), 8'($urandom_range(255)),
                   1'($urandom_range(1)));
    send_random_text(65);
  endtask

  initial begin
    in_valid       = 1'b0;
    in_item        = '0;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    mismatch_count = 0;
    send_idle_pct  = 26;
    recv_stall_pct = 77;
    tok_cfg.column_char     = COLUMN_CHAR_RST;
    tok_cfg.row_char        = ROW_CHAR_RST;
    tok_cfg.row_follow_char = ROW_FOLLOW_CHAR_RST;
    tok_cfg.quote_char      = QUOTE_CHAR_RST;
    tok_cfg.keep_quotes     = 1'b0;
    clear_tokenizer();
    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_basic_cells();
    test_default_stream();
    test_alternate_delimiters();

    send_idle_pct  = 77;
    recv_stall_pct = 26;
    test_low_register_values();
    test_high_register_values();

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_random_registers();
    test_random_registers();

    while (expected_cells.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && expected_cells.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
